@@ rtl/urlpd_pkg.sv @@
// Package for the URL percent decoder: byte constants, result and push types,
// and the hex digit decode. No dependencies.
package urlpd_pkg;

   localparam logic [7:0] EscapeChar  = 8'h25;
   localparam logic [7:0] DigitZero   = 8'h30;
   localparam logic [7:0] DigitNine   = 8'h39;
   localparam logic [7:0] LetterA     = 8'h41;
   localparam logic [7:0] LetterF     = 8'h46;
   localparam logic [7:0] LetterBase  = 8'h37;
   localparam int         ValueWidth  = 32;
   localparam int         BufDepth    = 2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       string_done;
      logic       run_last;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic       is_digit;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type hex_digit(input logic [7:0] b);
      digit_type d;
      logic [7:0] diff;
      d    = '0;
      diff = '0;
      if (b >= DigitZero && b <= DigitNine) begin
         diff       = b - DigitZero;
         d.is_digit = 1'b1;
         d.value    = diff[3:0];
      end else if (b >= LetterA && b <= LetterF) begin
         diff       = b - LetterBase;
         d.is_digit = 1'b1;
         d.value    = diff[3:0];
      end
      return d;
   endfunction

   // Positive as signed 32-bit and above 0x1F.
   function automatic logic value_emits(input logic [ValueWidth-1:0] v);
      return !v[ValueWidth-1] && (|v[ValueWidth-2:5]);
   endfunction

endpackage

@@ rtl/urlpd_req_if.sv @@
// Request channel of the URL percent decoder: one encoded byte per request.
// Depends on nothing.
interface urlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_final_byte;

   modport source (output valid, output in_byte, output is_final_byte, input ready);
   modport sink   (input valid, input in_byte, input is_final_byte, output ready);
endinterface

@@ rtl/urlpd_rsp_if.sv @@
// Response channel of the URL percent decoder: one decoded result per transfer.
// Depends on nothing.
interface urlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       string_done;
   logic       run_last;

   modport source (output valid, output out_byte, output has_byte, output string_done,
                   output run_last, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input string_done,
                   input run_last, output ready);
endinterface

@@ rtl/urlpd_core.sv @@
// Input register, escape state and single-pass decode of one request.
// Depends on urlpd_pkg and urlpd_req_if.
module urlpd_core (
   input  logic               clock,
   input  logic               reset,
   urlpd_req_if.sink          req_ch,
   input  logic [1:0]         free_slots,
   output urlpd_pkg::push_type push
);

   logic                                  in_valid_ff, in_valid_in;
   logic [7:0]                            in_byte_ff, in_byte_in;
   logic                                  in_final_ff, in_final_in;
   logic                                  escape_ff, escape_in;
   logic [urlpd_pkg::ValueWidth-1:0]      value_ff, value_in;

   urlpd_pkg::digit_type                  dig;
   urlpd_pkg::result_type                 res_a, res_b;
   logic                                  emit_close, emit_pass, emit_end;
   logic                                  escape_mid;
   logic [urlpd_pkg::ValueWidth-1:0]      value_mid;
   logic [1:0]                            count;
   logic                                  fire;

   always_comb begin
      dig        = urlpd_pkg::hex_digit(in_byte_ff);
      escape_mid = escape_ff;
      value_mid  = value_ff;
      emit_close = 1'b0;
      emit_pass  = 1'b0;
      if (escape_ff && dig.is_digit) begin
         value_mid = {value_ff[urlpd_pkg::ValueWidth-5:0], dig.value};
      end else begin
         if (escape_ff) begin
            emit_close = urlpd_pkg::value_emits(value_ff);
            escape_mid = 1'b0;
            value_mid  = '0;
         end
         if (in_byte_ff == urlpd_pkg::EscapeChar) begin
            escape_mid = 1'b1;
            value_mid  = '0;
         end else begin
            emit_pass = 1'b1;
         end
      end
      emit_end = in_final_ff && escape_mid && urlpd_pkg::value_emits(value_mid);

      count = {1'b0, emit_close} + {1'b0, emit_pass | emit_end};
      if (in_final_ff && count == 2'd0) begin
         count = 2'd1;
      end

      res_a = '0;
      if (emit_close) begin
         res_a.out_byte = value_ff[7:0];
         res_a.has_byte = 1'b1;
      end else if (emit_pass) begin
         res_a.out_byte = in_byte_ff;
         res_a.has_byte = 1'b1;
      end else if (emit_end) begin
         res_a.out_byte = value_mid[7:0];
         res_a.has_byte = 1'b1;
      end
      res_b          = '0;
      res_b.out_byte = in_byte_ff;
      res_b.has_byte = 1'b1;
      if (count == 2'd2) begin
         res_b.run_last    = 1'b1;
         res_b.string_done = in_final_ff;
      end else begin
         res_a.run_last    = 1'b1;
         res_a.string_done = in_final_ff;
      end

      fire        = in_valid_ff && (count <= free_slots);
      push.valid  = fire && (count != 2'd0);
      push.count  = count;
      push.first  = res_a;
      push.second = res_b;

      req_ch.ready = !in_valid_ff || fire;
      in_valid_in  = req_ch.valid || (in_valid_ff && !fire);
      in_byte_in   = in_byte_ff;
      in_final_in  = in_final_ff;
      if (req_ch.ready) begin
         in_byte_in  = req_ch.in_byte;
         in_final_in = req_ch.is_final_byte;
      end

      escape_in = escape_ff;
      value_in  = value_ff;
      if (fire) begin
         escape_in = escape_mid && !in_final_ff;
         value_in  = in_final_ff ? '0 : value_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         escape_ff   <= 1'b0;
         value_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         escape_ff   <= escape_in;
         value_ff    <= value_in;
      end
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
   end

endmodule

@@ rtl/urlpd_obuf.sv @@
// Two-entry result buffer that drives the response channel.
// Depends on urlpd_pkg and urlpd_rsp_if.
module urlpd_obuf (
   input  logic               clock,
   input  logic               reset,
   input  urlpd_pkg::push_type push,
   output logic [1:0]         free_slots,
   urlpd_rsp_if.source        rsp_ch
);

   urlpd_pkg::result_type slot_ff [urlpd_pkg::BufDepth];
   urlpd_pkg::result_type slot_in [urlpd_pkg::BufDepth];
   logic [1:0]            count_ff, count_in;
   logic                  pop;
   logic [1:0]            remain;
   urlpd_pkg::result_type head;

   always_comb begin
      rsp_ch.valid       = count_ff != 2'd0;
      rsp_ch.out_byte    = slot_ff[0].out_byte;
      rsp_ch.has_byte    = slot_ff[0].has_byte;
      rsp_ch.string_done = slot_ff[0].string_done;
      rsp_ch.run_last    = slot_ff[0].run_last;

      pop        = rsp_ch.valid && rsp_ch.ready;
      remain     = count_ff - {1'b0, pop};
      free_slots = 2'(urlpd_pkg::BufDepth) - remain;
      head       = pop ? slot_ff[1] : slot_ff[0];

      slot_in[0] = head;
      slot_in[1] = slot_ff[1];
      count_in   = remain;
      if (push.valid) begin
         count_in = remain + push.count;
         if (remain == 2'd0) begin
            slot_in[0] = push.first;
            slot_in[1] = push.second;
         end else begin
            slot_in[1] = push.first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

@@ rtl/url_percent_decoder_top.sv @@
// Top level of the URL percent decoder: input register and decode, then the
// result buffer. Depends on urlpd_pkg, urlpd_req_if, urlpd_rsp_if, urlpd_core, urlpd_obuf.
//
//   channel   direction  payload                                        results
//   req_ch    in         in_byte, is_final_byte                         -
//   rsp_ch    out        out_byte, has_byte, string_done, run_last      0..2 per request
//
// One request per cycle while the buffer has room; its first result passes the input
// register, then the result buffer, before rsp_ch presents it. The response side moves
// one result per cycle while rsp_ch.ready is high; a request lacking buffer room waits.
// Reset clears the escape state and empties both stages.
// A stalled response side fills the buffer; then only requests that yield no result pass.
module url_percent_decoder_top (
   input  logic        clock,
   input  logic        reset,
   urlpd_req_if.sink   req_ch,
   urlpd_rsp_if.source rsp_ch
);

   urlpd_pkg::push_type push;
   logic [1:0]          free_slots;

   urlpd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .free_slots (free_slots),
      .push       (push)
   );

   urlpd_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .free_slots (free_slots),
      .rsp_ch     (rsp_ch)
   );

endmodule

@@ tb/url_percent_decoder_top_tb.sv @@
// Testbench for url_percent_decoder_top: directed and random encoded strings under several
// handshake pressure phases, checked result by result against an in-bench decoder model.
// Depends on urlpd_pkg, urlpd_req_if, urlpd_rsp_if and the decoder RTL.
module url_percent_decoder_top_tb;

   localparam logic [7:0] LowerA = 8'h61;

   class percent_decode_scoreboard;
      bit                    in_esc;
      logic [31:0]           esc_val;
      urlpd_pkg::result_type decoded_queue[$];
      int                    errors;
      int                    requests_seen;
      int                    results_seen;

      function new();
         in_esc        = 1'b0;
         esc_val       = '0;
         errors        = 0;
         requests_seen = 0;
         results_seen  = 0;
      endfunction

      function automatic bit digit_of(input logic [7:0] b, output logic [3:0] dv);
         logic [7:0] diff;
         diff = '0;
         dv   = '0;
         if (b >= urlpd_pkg::DigitZero && b <= urlpd_pkg::DigitNine) begin
            diff = b - urlpd_pkg::DigitZero;
            dv   = diff[3:0];
            return 1'b1;
         end
         if (b >= urlpd_pkg::LetterA && b <= urlpd_pkg::LetterF) begin
            diff = b - urlpd_pkg::LetterA + 8'd10;
            dv   = diff[3:0];
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function automatic bit close_escape(output logic [7:0] eb);
         bit emit;
         emit    = !esc_val[31] && (esc_val > 32'h1F);
         eb      = esc_val[7:0];
         in_esc  = 1'b0;
         esc_val = '0;
         return emit;
      endfunction

      function automatic urlpd_pkg::result_type make_result(input logic [7:0] b,
                                                            input logic has);
         urlpd_pkg::result_type r;
         r.out_byte    = has ? b : 8'h00;
         r.has_byte    = has;
         r.string_done = 1'b0;
         r.run_last    = 1'b0;
         return r;
      endfunction

      function void note_request(input logic [7:0] b, input logic fin);
         urlpd_pkg::result_type res[$];
         logic [3:0]            dv;
         logic [7:0]            eb;
         bit                    handled;
         handled = 1'b0;
         requests_seen++;
         if (in_esc) begin
            if (digit_of(b, dv)) begin
               esc_val = {esc_val[27:0], dv};
               handled = 1'b1;
            end else if (close_escape(eb)) begin
               res.push_back(make_result(eb, 1'b1));
            end
         end
         if (!handled) begin
            if (b == urlpd_pkg::EscapeChar) begin
               in_esc  = 1'b1;
               esc_val = '0;
            end else begin
               res.push_back(make_result(b, 1'b1));
            end
         end
         if (fin) begin
            if (in_esc && close_escape(eb))
               res.push_back(make_result(eb, 1'b1));
            if (res.size() == 0)
               res.push_back(make_result(8'h00, 1'b0));
            res[res.size()-1].string_done = 1'b1;
            in_esc  = 1'b0;
            esc_val = '0;
         end
         if (res.size() > 0)
            res[res.size()-1].run_last = 1'b1;
         foreach (res[i])
            decoded_queue.push_back(res[i]);
      endfunction

      function void check_result(input urlpd_pkg::result_type got);
         urlpd_pkg::result_type want;
         results_seen++;
         if (decoded_queue.size() == 0) begin
            $error("unexpected result: out_byte %0h has_byte %0b string_done %0b run_last %0b",
                   got.out_byte, got.has_byte, got.string_done, got.run_last);
            errors++;
            return;
         end
         want = decoded_queue.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
            errors++;
         end
         if (got.string_done !== want.string_done) begin
            $error("string_done: expected %0b, got %0b", want.string_done, got.string_done);
            errors++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
            errors++;
         end
      endfunction

      function int pending();
         return decoded_queue.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   items_sent;

   percent_decode_scoreboard sb = new();

   urlpd_req_if req_ch();
   urlpd_rsp_if rsp_ch();

   url_percent_decoder_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request(req_ch.in_byte, req_ch.is_final_byte);
   end

   always @(posedge clock) begin
      urlpd_pkg::result_type got;
      got.out_byte    = rsp_ch.out_byte;
      got.has_byte    = rsp_ch.has_byte;
      got.string_done = rsp_ch.string_done;
      got.run_last    = rsp_ch.run_last;
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(got);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [7:0] hex_char(input int n);
      return (n < 10) ? urlpd_pkg::DigitZero + 8'(n) : urlpd_pkg::LetterA + 8'(n - 10);
   endfunction

   task automatic send_request(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.in_byte       <= b;
      req_ch.is_final_byte <= fin;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], i == s.len() - 1);
   endtask

   task automatic send_random_string();
      logic [7:0] q[$];
      int         ntok;
      int         kind;
      int         k;
      int         ndig;
      ntok = $urandom_range(1, 6);
      repeat (ntok) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            q.push_back(8'($urandom_range(255)));
         end else if (kind < 50) begin
            q.push_back(LowerA + 8'($urandom_range(5)));
         end else begin
            q.push_back(urlpd_pkg::EscapeChar);
            k = $urandom_range(99);
            if (k < 10)
               ndig = 0;
            else if (k < 70)
               ndig = 2;
            else if (k < 85)
               ndig = $urandom_range(1, 3);
            else
               ndig = $urandom_range(4, 10);
            repeat (ndig) q.push_back(hex_char($urandom_range(15)));
         end
      end
      foreach (q[i])
         send_request(q[i], i == q.size() - 1);
   endtask

   initial begin
      int waited;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.in_byte       = 8'h00;
      req_ch.is_final_byte = 1'b0;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      items_sent           = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, dropped escapes, escape closed by escape, bare escape at end
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);
      send_text("%1Fa");
      send_text("%%20");
      send_text("%");
      send_text("%F0000004G");
      send_text("%7E");

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 69;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 69;
            end
            default: begin
               send_idle_pct  = 35;
               recv_stall_pct = 35;
            end
         endcase
         while (items_sent < 24 + (phase + 1) * 257)
            send_random_string();
      end
      req_ch.valid <= 1'b0;

      waited = 0;
      while (sb.pending() > 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending() > 0) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         repeat (20) @(posedge clock);
         if (sb.pending() > 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
         end
         $display("Decoded %0d requests into %0d results across four pressure phases.",
                  sb.requests_seen, sb.results_seen);
         $display("Mismatches found: %0d", sb.errors);
         if (sb.errors == 0)
            $display("PASSED: all results match");
         else
            $display("FAILED: results differ");
         $finish;
      end
   end
endmodule

@@ sim.f @@
rtl/urlpd_pkg.sv
rtl/urlpd_req_if.sv
rtl/urlpd_rsp_if.sv
rtl/urlpd_core.sv
rtl/urlpd_obuf.sv
rtl/url_percent_decoder_top.sv
tb/url_percent_decoder_top_tb.sv
